// File: rtl/closest_pair_min_sq_distance_defines.svh
// ----------------------------------------------------------------------------
// closest pair assertion macros
// shared concurrent assertion forms used by the rtl blocks
// ----------------------------------------------------------------------------
`ifndef CLOSEST_PAIR_MIN_SQ_DISTANCE_DEFINES_SVH
`define CLOSEST_PAIR_MIN_SQ_DISTANCE_DEFINES_SVH

// same-cycle implication
`define CPMSD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CPMSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/cpmsd_pkg.sv
// ----------------------------------------------------------------------------
// cpmsd_pkg
// types and constants shared by the closest pair blocks
// ----------------------------------------------------------------------------
package cpmsd_pkg;

   localparam int MAX_POINTS_DEFAULT = 64;
   localparam int COORD_BITS         = 16;
   localparam int DIST_BITS          = 33;
   localparam int COUNT_OUT_BITS     = 7;
   localparam int QCNT_BITS          = 13;
   localparam int QUEUE_DEPTH        = 2;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [DIST_BITS-1:0]         dist_type;

   typedef struct packed {
      coord_type x_coord;
      coord_type y_coord;
      logic      last_point;
   } req_payload_type;

   typedef struct packed {
      dist_type                  min_sq_distance;
      logic                      no_pair;
      logic                      points_dropped;
      logic [COUNT_OUT_BITS-1:0] point_count;
   } rsp_payload_type;

   // one classified point between the front and the back
   typedef struct packed {
      coord_type            x_coord;
      coord_type            y_coord;
      logic                 last_point;
      logic                 store;
      logic                 dropped;
      logic [QCNT_BITS-1:0] cnt;
   } queue_entry_type;

endpackage

// File: rtl/cpmsd_stream_if.sv
// ----------------------------------------------------------------------------
// cpmsd_stream_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
interface cpmsd_stream_if #(
   parameter type payload_type = logic [0:0]
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/cpmsd_queue.sv
// ----------------------------------------------------------------------------
// cpmsd_queue
// short fifo of classified points between front and back
// ----------------------------------------------------------------------------
module cpmsd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  cpmsd_pkg::queue_entry_type entry_in,
   output logic                       full,
   input  logic                       pop,
   output logic                       head_valid,
   output cpmsd_pkg::queue_entry_type head
);
   import cpmsd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   queue_entry_type    slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               do_push, do_pop;

   assign full       = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         fill_in = FILL_W'(fill_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         fill_in = FILL_W'(fill_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

// File: rtl/cpmsd_front.sv
// ----------------------------------------------------------------------------
// cpmsd_front
// accepts point beats, decides store or drop, tracks set count and overflow
// ----------------------------------------------------------------------------
module cpmsd_front #(
   parameter int MAX_POINTS = cpmsd_pkg::MAX_POINTS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   cpmsd_stream_if.sink               req_chan,
   output logic                       push,
   output cpmsd_pkg::queue_entry_type entry_out,
   input  logic                       full
);
   import cpmsd_pkg::*;

   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ovf_ff, ovf_in;
   logic             store;
   req_payload_type  beat;

   assign beat           = req_chan.payload;
   assign req_chan.ready = !full;
   assign push           = req_chan.valid && !full;
   assign store          = (cnt_ff < CNT_W'(MAX_POINTS));

   always_comb begin
      entry_out.x_coord    = beat.x_coord;
      entry_out.y_coord    = beat.y_coord;
      entry_out.last_point = beat.last_point;
      entry_out.store      = store;
      entry_out.dropped    = ovf_ff || !store;
      entry_out.cnt        = QCNT_BITS'(cnt_ff);
   end

   always_comb begin
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      if (push) begin
         if (beat.last_point) begin
            cnt_in = '0;
            ovf_in = 1'b0;
         end else if (store) begin
            cnt_in = CNT_W'(cnt_ff + 1'b1);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
      end
   end

endmodule

// File: rtl/cpmsd_back.sv
// ----------------------------------------------------------------------------
// cpmsd_back
// point store, pipelined distance scan, running minimum and result register
// ----------------------------------------------------------------------------
`include "closest_pair_min_sq_distance_defines.svh"

module cpmsd_back #(
   parameter int MAX_POINTS = cpmsd_pkg::MAX_POINTS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       head_valid,
   input  cpmsd_pkg::queue_entry_type head,
   output logic                       pop,
   cpmsd_stream_if.source             rsp_chan
);
   import cpmsd_pkg::*;

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int SQ_W  = 2 * COORD_BITS;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_EMIT} state_type;

   state_type            state_ff, state_in;
   queue_entry_type      cur_ff, cur_in;
   logic [IDX_W-1:0]     scan_idx_ff, scan_idx_in;
   dist_type             min_ff, min_in;
   logic                 rd_v_ff, ad_v_ff, sq_v_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_payload_ff, rsp_payload_in;

   coord_type            mem_x [MAX_POINTS];
   coord_type            mem_y [MAX_POINTS];
   coord_type            rd_x_ff, rd_y_ff;
   logic [COORD_BITS-1:0] ad_x_ff, ad_y_ff, ad_x_in, ad_y_in;
   logic [SQ_W-1:0]      sq_x_ff, sq_y_ff;
   logic signed [COORD_BITS:0] dx, dy;
   dist_type             sum;

   logic                 rd_en, wr_en, pipe_busy, last_scan, emit_go, no_pair;
   logic [IDX_W-1:0]     cur_idx, wr_addr;
   logic [QCNT_BITS-1:0] fin_cnt;

   assign pop       = (state_ff == S_IDLE) && head_valid;
   assign wr_en     = pop && head.store;
   assign wr_addr   = head.cnt[IDX_W-1:0];
   assign rd_en     = (state_ff == S_SCAN);
   assign cur_idx   = cur_ff.cnt[IDX_W-1:0];
   assign last_scan = (IDX_W'(scan_idx_ff + 1'b1) == cur_idx);
   assign pipe_busy = rd_v_ff || ad_v_ff || sq_v_ff;
   assign emit_go   = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_chan.ready);
   assign fin_cnt   = QCNT_BITS'(cur_ff.cnt + QCNT_BITS'(cur_ff.store));
   assign no_pair   = (fin_cnt < QCNT_BITS'(2));

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   // distance datapath
   assign dx      = {rd_x_ff[COORD_BITS-1], rd_x_ff} - {cur_ff.x_coord[COORD_BITS-1], cur_ff.x_coord};
   assign dy      = {rd_y_ff[COORD_BITS-1], rd_y_ff} - {cur_ff.y_coord[COORD_BITS-1], cur_ff.y_coord};
   assign ad_x_in = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
   assign ad_y_in = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
   assign sum     = DIST_BITS'(sq_x_ff) + DIST_BITS'(sq_y_ff);

   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      scan_idx_in    = scan_idx_ff;
      min_in         = min_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_payload_in = rsp_payload_ff;

      if (sq_v_ff && (sum < min_ff)) begin
         min_in = sum;
      end

      case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               cur_in      = head;
               scan_idx_in = '0;
               if (head.store && (head.cnt != '0)) begin
                  state_in = S_SCAN;
               end else if (head.last_point) begin
                  state_in = S_EMIT;
               end
            end
         end
         S_SCAN: begin
            scan_idx_in = IDX_W'(scan_idx_ff + 1'b1);
            if (last_scan) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!pipe_busy) begin
               state_in = cur_ff.last_point ? S_EMIT : S_IDLE;
            end
         end
         S_EMIT: begin
            if (emit_go) begin
               rsp_valid_in                   = 1'b1;
               rsp_payload_in.min_sq_distance = no_pair ? '0 : min_ff;
               rsp_payload_in.no_pair         = no_pair;
               rsp_payload_in.points_dropped  = cur_ff.dropped;
               rsp_payload_in.point_count     = COUNT_OUT_BITS'(fin_cnt);
               min_in                         = '1;
               state_in                       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         min_ff       <= '1;
         rd_v_ff      <= 1'b0;
         ad_v_ff      <= 1'b0;
         sq_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_ff       <= min_in;
         rd_v_ff      <= rd_en;
         ad_v_ff      <= rd_v_ff;
         sq_v_ff      <= ad_v_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff         <= cur_in;
      scan_idx_ff    <= scan_idx_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // point store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x[wr_addr] <= head.x_coord;
         mem_y[wr_addr] <= head.y_coord;
      end
      if (rd_en) begin
         rd_x_ff <= mem_x[scan_idx_ff];
         rd_y_ff <= mem_y[scan_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      ad_x_ff <= ad_x_in;
      ad_y_ff <= ad_y_in;
      sq_x_ff <= SQ_W'(ad_x_ff) * SQ_W'(ad_x_ff);
      sq_y_ff <= SQ_W'(ad_y_ff) * SQ_W'(ad_y_ff);
   end

   `CPMSD_ASSERT_NOW(a_pipe_only_in_scan, clock, reset,
      pipe_busy, (state_ff == S_SCAN) || (state_ff == S_DRAIN),
      "distance pipeline active outside scan")
   `CPMSD_ASSERT_NOW(a_scan_below_count, clock, reset,
      state_ff == S_SCAN, (scan_idx_ff < cur_idx) && cur_ff.store,
      "scan address beyond stored points")
   `CPMSD_ASSERT_NEXT(a_emit_clears_min, clock, reset,
      emit_go, rsp_valid_ff && (min_ff == '1) && (state_ff == S_IDLE),
      "result load did not clear the set")
   `CPMSD_ASSERT_NOW(a_pop_only_idle, clock, reset,
      pop, (state_ff == S_IDLE) && !pipe_busy,
      "queue popped while busy")

endmodule

// File: rtl/closest_pair_min_sq_distance.sv
// ----------------------------------------------------------------------------
// closest_pair_min_sq_distance
// smallest squared distance between the points of a set
// ----------------------------------------------------------------------------
// usage:
//   req_chan carries one point per beat (x_coord, y_coord, last_point).
//   rsp_chan carries one result beat per set, issued after the point that
//   has last_point set: min_sq_distance, no_pair, points_dropped, point_count.
//   a front stage classifies each point (store or drop past MAX_POINTS) and
//   places it in a two-entry queue; the back stage writes each stored point
//   into the store as it leaves the queue and compares it against the points
//   stored before it, one store read per cycle through a pipelined distance
//   datapath. the back takes the next point from the queue only once the
//   pipeline has drained for the current one. the result of a set is loaded
//   into the output register from the emit state, entered once the scan of
//   its final point has drained or when a final point with nothing to
//   compare leaves the queue.
//   reset empties the queue, the set count and the result register; the
//   point store needs no clearing since only written entries are read.
//   a stalled rsp_chan holds the result in its output register while the
//   next set is still accepted; the back waits only when a new result is
//   ready and the previous one has not been taken.
// ----------------------------------------------------------------------------
module closest_pair_min_sq_distance #(
   parameter int MAX_POINTS = cpmsd_pkg::MAX_POINTS_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   cpmsd_stream_if.sink   req_chan,
   cpmsd_stream_if.source rsp_chan
);
   import cpmsd_pkg::*;

   logic            push, full, pop, head_valid;
   queue_entry_type entry, head;

   cpmsd_front #(
      .MAX_POINTS (MAX_POINTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .push      (push),
      .entry_out (entry),
      .full      (full)
   );

   cpmsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .entry_in   (entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   cpmsd_back #(
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

// File: dv/tb_closest_pair_min_sq_distance.sv
// ----------------------------------------------------------------------------
// tb_closest_pair_min_sq_distance
// self-checking bench: point sets in, smallest squared distance out
// ----------------------------------------------------------------------------
// point sets are queued by the stimulus process and sent one beat at a time
// with random gaps. every accepted point is folded into a local running
// minimum over the points kept so far, and a set's last point queues the
// expected result. each result beat is compared field by field against the
// oldest expected one. sets cover single points, duplicates, extreme
// coordinates, exactly full stores and sets that overflow the store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_closest_pair_min_sq_distance;
   import cpmsd_pkg::*;

   localparam int     MAX_PTS  = MAX_POINTS_DEFAULT;
   localparam longint DIST_MAX = (64'd1 << DIST_BITS) - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cpmsd_stream_if #(.payload_type(req_payload_type)) req_if ();
   cpmsd_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   closest_pair_min_sq_distance #(.MAX_POINTS(MAX_PTS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   req_payload_type point_queue[$];
   rsp_payload_type owed_results[$];

   coord_type kept_x [MAX_PTS];
   coord_type kept_y [MAX_PTS];
   int        kept_n   = 0;
   dist_type  run_min  = '1;
   logic      spilled  = 1'b0;

   int   fails         = 0;
   int   sets_closed   = 0;
   int   points_in     = 0;
   int   lonely_sets   = 0;
   int   spilled_sets  = 0;
   int   full_sets     = 0;
   int   results_seen  = 0;
   int   cycle_no      = 0;
   logic req_fire      = 1'b0;

   // fold one accepted point into the running minimum of its set
   function automatic void fold_point(req_payload_type p);
      longint          dx, dy, d;
      rsp_payload_type r;
      points_in++;
      if (kept_n < MAX_PTS) begin
         for (int i = 0; i < kept_n; i++) begin
            dx = longint'(p.x_coord) - longint'(kept_x[i]);
            dy = longint'(p.y_coord) - longint'(kept_y[i]);
            d  = dx * dx + dy * dy;
            if (d > DIST_MAX) d = DIST_MAX;
            if (dist_type'(d) < run_min) run_min = dist_type'(d);
         end
         kept_x[kept_n] = p.x_coord;
         kept_y[kept_n] = p.y_coord;
         kept_n++;
      end else begin
         spilled = 1'b1;
      end
      if (p.last_point) begin
         r.no_pair         = (kept_n < 2);
         r.min_sq_distance = r.no_pair ? '0 : run_min;
         r.points_dropped  = spilled;
         r.point_count     = kept_n[COUNT_OUT_BITS-1:0];
         owed_results      = {owed_results, r};
         sets_closed++;
         if (r.no_pair) lonely_sets++;
         if (spilled) spilled_sets++;
         if (kept_n == MAX_PTS) full_sets++;
         kept_n  = 0;
         run_min = '1;
         spilled = 1'b0;
      end
   endfunction

   function automatic bit quiet_stretch();
      return (cycle_no % 3000) >= 2300;
   endfunction

   // driver
   always @(negedge clock) begin
      cycle_no <= cycle_no + 1;
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.payload <= '0;
         rsp_if.ready   <= 1'b0;
      end else begin
         rsp_if.ready <= quiet_stretch() || ($urandom_range(99) >= 18);
         if (!req_if.valid || req_fire) begin
            if (point_queue.size() != 0 &&
                (quiet_stretch() || $urandom_range(99) >= 18)) begin
               req_if.valid   <= 1'b1;
               req_if.payload <= point_queue.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_payload_type got, want;
      req_fire <= !reset && req_if.valid && req_if.ready;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         results_seen++;
         if (owed_results.size() == 0) begin
            $display("%0t: result beat with none expected: min %0d no_pair %0b dropped %0b count %0d",
                     $time, got.min_sq_distance, got.no_pair, got.points_dropped,
                     got.point_count);
            fails++;
         end else begin
            want = owed_results.pop_front();
            if (got.min_sq_distance !== want.min_sq_distance) begin
               $display("%0t: min_sq_distance expected %0d actual %0d",
                        $time, want.min_sq_distance, got.min_sq_distance);
               fails++;
            end
            if (got.no_pair !== want.no_pair) begin
               $display("%0t: no_pair expected %0b actual %0b",
                        $time, want.no_pair, got.no_pair);
               fails++;
            end
            if (got.points_dropped !== want.points_dropped) begin
               $display("%0t: points_dropped expected %0b actual %0b",
                        $time, want.points_dropped, got.points_dropped);
               fails++;
            end
            if (got.point_count !== want.point_count) begin
               $display("%0t: point_count expected %0d actual %0d",
                        $time, want.point_count, got.point_count);
               fails++;
            end
         end
      end
      if (!reset && req_if.valid && req_if.ready) fold_point(req_if.payload);
   end

   task automatic add_point(input int x, input int y, input bit last);
      req_payload_type p;
      p.x_coord    = coord_type'(x);
      p.y_coord    = coord_type'(y);
      p.last_point = last;
      point_queue  = {point_queue, p};
   endtask

   // one set of n points; style picks wide, clustered or extreme coordinates
   task automatic add_random_set(input int n);
      int style, base_x, base_y, spread, x, y;
      int corners [6] = '{-32768, -32767, -1, 0, 1, 32767};
      style  = $urandom_range(2);
      base_x = $urandom_range(65535);
      base_y = $urandom_range(65535);
      spread = $urandom_range(255);
      for (int i = 0; i < n; i++) begin
         case (style)
            0: begin
               x = $urandom_range(65535);
               y = $urandom_range(65535);
            end
            1: begin
               x = base_x + $urandom_range(2 * spread) - spread;
               y = base_y + $urandom_range(2 * spread) - spread;
            end
            default: begin
               x = corners[$urandom_range(5)];
               y = corners[$urandom_range(5)];
            end
         endcase
         add_point(x, y, i == n - 1);
      end
   endtask

   initial begin
      int total;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;

      // single point, then the widest possible pair
      add_point(123, -456, 1'b1);
      add_point(-32768, -32768, 1'b0);
      add_point(32767, 32767, 1'b1);
      // duplicates, then the opposite diagonal pair, mixed small sets and one more single point
      add_point(5, 5, 1'b0);
      add_point(5, 5, 1'b1);
      add_point(32767, -32768, 1'b0);
      add_point(-32768, 32767, 1'b1);
      add_point(0, 0, 1'b0);
      add_point(-1, -1, 1'b0);
      add_point(32767, 0, 1'b0);
      add_point(0, -32768, 1'b1);
      add_point(-32768, 0, 1'b1);
      add_point(100, 200, 1'b0);
      add_point(103, 204, 1'b0);
      add_point(-7000, 9000, 1'b0);
      add_point(100, 201, 1'b1);

      // full store, last point dropped on a full store, long overflow
      add_random_set(MAX_PTS);
      add_random_set(MAX_PTS + 1);
      add_random_set(MAX_PTS + 6);

      total = point_queue.size();
      while (total < 550) begin
         int n;
         n = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(10, 1);
         add_random_set(n);
         total += n;
      end

      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (point_queue.size() != 0 || req_if.valid || owed_results.size() != 0)
         @(negedge clock);
      repeat (300) @(negedge clock);

      $display("covered %0d sets from %0d points: %0d single-point, %0d full, %0d overflowing",
               sets_closed, points_in, lonely_sets, full_sets, spilled_sets);
      $display("checked %0d result beats", results_seen);
      if (fails == 0) begin
         $display("[closest_pair_min_sq_distance] OK");
      end else begin
         $display("[closest_pair_min_sq_distance] ERROR");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("timeout with %0d points and %0d results outstanding",
               point_queue.size(), owed_results.size());
      $display("[closest_pair_min_sq_distance] ERROR");
      $finish;
   end

endmodule
